FILE: rtl/core/tieb_pkg.sv
// shared types, constants and queue index helpers for the trigger id event builder
`default_nettype none
package tieb_pkg;

    localparam int NUM_PRODUCERS = 4;
    localparam int QUEUE_DEPTH   = 16;
    localparam int MAX_RESULTS   = 16;

    localparam int PROD_W = (NUM_PRODUCERS > 1) ? $clog2(NUM_PRODUCERS) : 1;
    localparam int HEAD_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(NUM_PRODUCERS * QUEUE_DEPTH);
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] NO_TRIGGER  = 32'hFFFF_FFFF;
    localparam logic [3:0]  MASK_RST    = 4'hF;
    localparam logic [15:0] TIMEOUT_RST = 16'd500;

    // request types
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // result kinds
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_DROP   = 1'b1;

    // register indexes
    localparam logic REG_ENABLED = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN_RD = 7'b0000010,
        S_SCAN_LD = 7'b0000100,
        S_CHECK   = 7'b0001000,
        S_MAX     = 7'b0010000,
        S_EMIT    = 7'b0100000,
        S_FINISH  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  producer;
        logic [31:0] trigger_id;
        logic [15:0] payload;
    } t_req;

    typedef struct packed {
        logic        kind;
        logic [31:0] packet_trigger;
        logic [15:0] payload_p0;
        logic [15:0] payload_p1;
        logic [15:0] payload_p2;
        logic [15:0] payload_p3;
        logic [3:0]  filler_mask;
        logic [3:0]  present_mask;
        logic        any_fill;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [31:0] trig;
        logic [15:0] pay;
        logic        fill;
        logic [31:0] arr;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_wr;

    // slot behind the last entry
    function automatic logic [HEAD_W-1:0] slot_tail(input logic [HEAD_W-1:0] head,
                                                    input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(cnt);
        if (s >= SUM_W'(QUEUE_DEPTH))
            s = s - SUM_W'(QUEUE_DEPTH);
        return HEAD_W'(s);
    endfunction

    function automatic logic [HEAD_W-1:0] slot_prev(input logic [HEAD_W-1:0] head);
        return (head == '0) ? HEAD_W'(QUEUE_DEPTH - 1) : head - HEAD_W'(1);
    endfunction

    function automatic logic [HEAD_W-1:0] slot_next(input logic [HEAD_W-1:0] head);
        return (head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head + HEAD_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [PROD_W-1:0] p,
                                                    input logic [HEAD_W-1:0] slot);
        return ADDR_W'(p) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tieb_qmem.sv
// sub-event queue storage for all producers, one write and one registered read port
`default_nettype none
module tieb_qmem (
    input  logic                      i_clk,
    input  tieb_pkg::t_wr             i_wr,
    input  logic [tieb_pkg::ADDR_W-1:0] i_rd_addr,
    output tieb_pkg::t_entry          o_rd_data
);
    import tieb_pkg::*;

    t_entry r_mem [NUM_PRODUCERS*QUEUE_DEPTH];
    t_entry r_rd;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule
`default_nettype wire

FILE: rtl/core/trigger_id_event_builder.sv
// top level of the trigger id event builder: sequencer, queue control and ports
// Each request is either an arrival (queued at the back of its producer's queue,
// stamped with the current tick time) or a tick (time advances by one). After every
// request the block builds packets for as long as it can, up to 16 results per
// request, the last one flagged. One build attempt reads the producer fronts from
// the shared queue memory one at a time (a read state and a load state per
// producer), then walks the producers once through the shared compare unit (plus
// the oldest-age scan over the queues for every empty enabled one), then pops and
// emits. A request that finds no target ends after the front reads; a stalled
// output holds the block in its emit or finish step. The block takes no new
// request until all results of the current one are handed to the output register.
// Configuration is to be written through the APB port while the block is idle;
// the block itself does not enforce this.
`default_nettype none
module trigger_id_event_builder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tieb_pkg::t_req   i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output tieb_pkg::t_res   o_res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tieb_pkg::*;

    t_state              r_state, n_state;
    logic [PROD_W-1:0]   r_k, n_k;
    logic [PROD_W-1:0]   r_q, n_q;
    logic [HEAD_W-1:0]   r_head [NUM_PRODUCERS];
    logic [HEAD_W-1:0]   n_head [NUM_PRODUCERS];
    logic [CNT_W-1:0]    r_cnt [NUM_PRODUCERS];
    logic [CNT_W-1:0]    n_cnt [NUM_PRODUCERS];
    logic [31:0]         r_ftrig [NUM_PRODUCERS];
    logic [31:0]         n_ftrig [NUM_PRODUCERS];
    logic [31:0]         r_fage [NUM_PRODUCERS];
    logic [31:0]         n_fage [NUM_PRODUCERS];
    logic                r_ffill [NUM_PRODUCERS];
    logic                n_ffill [NUM_PRODUCERS];
    logic [15:0]         r_fpay [NUM_PRODUCERS];
    logic [15:0]         n_fpay [NUM_PRODUCERS];
    logic [31:0]         r_time, n_time;
    logic [3:0]          r_mask;
    logic [15:0]         r_timeout;
    logic [31:0]         r_target, n_target;
    logic [31:0]         r_max, n_max;
    logic                r_ready, n_ready;
    logic [NRES_W-1:0]   r_n, n_n;
    logic                r_pend_v, n_pend_v;
    t_res                r_pend, n_pend;
    logic                r_out_v, n_out_v;
    t_res                r_out, n_out;

    logic [NUM_PRODUCERS-1:0] en;
    t_wr                 wr;
    t_entry              rd;
    logic [ADDR_W-1:0]   rd_addr;
    t_res                built;

    // queue memory
    tieb_qmem u_qmem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd)
    );

    assign rd_addr = slot_addr(r_k, r_head[r_k]);

    // per producer enable from the 4 bit mask
    always_comb begin
        for (int p = 0; p < NUM_PRODUCERS; p++) begin
            en[p] = (p < 4) ? r_mask[p % 4] : 1'b0;
        end
    end

    // packet assembled from the current fronts
    always_comb begin
        built = '0;
        built.kind = KIND_PACKET;
        built.packet_trigger = r_target;
        for (int p = 0; p < NUM_PRODUCERS; p++) begin
            if (en[p] && r_cnt[p] != '0 && p < 4) begin
                built.present_mask[p % 4] = 1'b1;
                built.filler_mask[p % 4] = r_ffill[p];
                if (p == 0) built.payload_p0 = r_fpay[p];
                if (p == 1) built.payload_p1 = r_fpay[p];
                if (p == 2) built.payload_p2 = r_fpay[p];
                if (p == 3) built.payload_p3 = r_fpay[p];
            end
        end
        built.any_fill = (built.filler_mask != '0);
    end

    // sequencer
    always_comb begin
        logic              do_adv;
        logic              do_push;
        logic              out_free;
        logic              out_load;
        t_res              out_data;
        logic [PROD_W-1:0] pi;
        logic [HEAD_W-1:0] hp;
        logic [31:0]       cand;

        n_state  = r_state;
        n_k      = r_k;
        n_q      = r_q;
        n_head   = r_head;
        n_cnt    = r_cnt;
        n_ftrig  = r_ftrig;
        n_fage   = r_fage;
        n_ffill  = r_ffill;
        n_fpay   = r_fpay;
        n_time   = r_time;
        n_target = r_target;
        n_max    = r_max;
        n_ready  = r_ready;
        n_n      = r_n;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = r_out_v;
        n_out    = r_out;
        wr       = '0;
        do_adv   = 1'b0;
        do_push  = 1'b0;
        out_free = !r_out_v || i_ready;
        out_load = 1'b0;
        out_data = r_pend;
        pi       = PROD_W'(i_req.producer);
        hp       = slot_prev(r_head[r_k]);
        cand     = r_max;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_k      = '0;
                    n_target = NO_TRIGGER;
                    n_n      = '0;
                    n_pend_v = 1'b0;
                    n_state  = S_SCAN_RD;
                    if (i_req.req_type == REQ_TICK) begin
                        n_time = r_time + 32'd1;
                    end else if (int'(i_req.producer) < NUM_PRODUCERS) begin
                        if (r_cnt[pi] == CNT_W'(QUEUE_DEPTH)) begin
                            // queue full: report the dropped arrival
                            n_pend = '0;
                            n_pend.kind = KIND_DROP;
                            n_pend.packet_trigger = i_req.trigger_id;
                            unique case (i_req.producer)
                                2'd0: n_pend.payload_p0 = i_req.payload;
                                2'd1: n_pend.payload_p1 = i_req.payload;
                                2'd2: n_pend.payload_p2 = i_req.payload;
                                default: n_pend.payload_p3 = i_req.payload;
                            endcase
                            n_pend.present_mask = 4'd1 << i_req.producer;
                            n_pend_v = 1'b1;
                            n_n = NRES_W'(1);
                        end else begin
                            wr.en = 1'b1;
                            wr.addr = slot_addr(pi, slot_tail(r_head[pi], r_cnt[pi]));
                            wr.data = '{trig: i_req.trigger_id, pay: i_req.payload,
                                        fill: 1'b0, arr: r_time};
                            n_cnt[pi] = r_cnt[pi] + CNT_W'(1);
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_LD;
            end
            S_SCAN_LD: begin
                // capture one front and track the smallest trigger
                if (r_cnt[r_k] != '0) begin
                    n_ftrig[r_k] = rd.trig;
                    n_fage[r_k]  = r_time - rd.arr;
                    n_ffill[r_k] = rd.fill;
                    n_fpay[r_k]  = rd.pay;
                    if (en[r_k] && rd.trig < r_target) begin
                        n_target = rd.trig;
                    end
                end
                if (r_k == PROD_W'(NUM_PRODUCERS - 1)) begin
                    n_k = '0;
                    n_ready = 1'b1;
                    n_state = (n_target == NO_TRIGGER) ? S_FINISH : S_CHECK;
                end else begin
                    n_k = r_k + PROD_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_CHECK: begin
                do_adv = 1'b1;
                if (!en[r_k]) begin
                    do_adv = 1'b1;
                end else if (r_cnt[r_k] == '0) begin
                    do_adv = 1'b0;
                    n_q = '0;
                    n_max = '0;
                    n_state = S_MAX;
                end else if (r_ftrig[r_k] != r_target) begin
                    if (r_fage[r_k] >= 32'(r_timeout) && r_cnt[r_k] < CNT_W'(QUEUE_DEPTH))
                        do_push = 1'b1;
                    else
                        n_ready = 1'b0;
                end
            end
            S_MAX: begin
                // oldest front age over all non-empty queues
                if (r_cnt[r_q] != '0 && r_fage[r_q] > r_max)
                    cand = r_fage[r_q];
                n_max = cand;
                if (r_q == PROD_W'(NUM_PRODUCERS - 1)) begin
                    do_adv = 1'b1;
                    if (cand >= 32'(r_timeout))
                        do_push = 1'b1;
                    else
                        n_ready = 1'b0;
                end else begin
                    n_q = r_q + PROD_W'(1);
                end
            end
            S_EMIT: begin
                if (!r_ready) begin
                    n_state = S_FINISH;
                end else if (!r_pend_v || out_free) begin
                    out_load = r_pend_v;
                    n_pend = built;
                    n_pend_v = 1'b1;
                    for (int p = 0; p < NUM_PRODUCERS; p++) begin
                        if (en[p] && r_cnt[p] != '0) begin
                            n_head[p] = slot_next(r_head[p]);
                            n_cnt[p] = r_cnt[p] - CNT_W'(1);
                        end
                    end
                    n_n = r_n + NRES_W'(1);
                    if (n_n == NRES_W'(MAX_RESULTS)) begin
                        n_state = S_FINISH;
                    end else begin
                        n_k = '0;
                        n_target = NO_TRIGGER;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_FINISH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    out_load = 1'b1;
                    out_data.last = 1'b1;
                    n_pend_v = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // filler pushed at the front of the current producer
        if (do_push) begin
            wr.en = 1'b1;
            wr.addr = slot_addr(r_k, hp);
            wr.data = '{trig: r_target, pay: 16'h0, fill: 1'b1, arr: r_time};
            n_head[r_k]  = hp;
            n_cnt[r_k]   = r_cnt[r_k] + CNT_W'(1);
            n_ftrig[r_k] = r_target;
            n_fage[r_k]  = '0;
            n_ffill[r_k] = 1'b1;
            n_fpay[r_k]  = '0;
        end

        // step to the next producer check
        if (do_adv) begin
            if (r_k == PROD_W'(NUM_PRODUCERS - 1)) begin
                n_state = S_EMIT;
            end else begin
                n_k = r_k + PROD_W'(1);
                n_state = S_CHECK;
            end
        end

        // output register
        if (out_load) begin
            n_out_v = 1'b1;
            n_out = out_data;
        end else if (i_ready) begin
            n_out_v = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_q      <= '0;
            r_time   <= '0;
            r_ready  <= 1'b0;
            r_n      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_mask   <= MASK_RST;
            r_timeout <= TIMEOUT_RST;
            for (int p = 0; p < NUM_PRODUCERS; p++) begin
                r_head[p] <= '0;
                r_cnt[p]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_q      <= n_q;
            r_time   <= n_time;
            r_ready  <= n_ready;
            r_n      <= n_n;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_head   <= n_head;
            r_cnt    <= n_cnt;
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_TIMEOUT)
                    r_timeout <= pwdata[15:0];
                else
                    r_mask <= pwdata[3:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ftrig  <= n_ftrig;
        r_fage   <= n_fage;
        r_ffill  <= n_ffill;
        r_fpay   <= n_fpay;
        r_target <= n_target;
        r_max    <= n_max;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    // ports
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_TIMEOUT) ? {16'h0, r_timeout} : {28'h0, r_mask};

    // no result left behind when a new request can be taken
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending result while idle");

    // queue memory written only on arrival or filler push
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_state == S_IDLE || r_state == S_CHECK || r_state == S_MAX))
        else $error("queue write outside arrival or filler push");

    // result count stays within the cap
    a_res_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NRES_W'(MAX_RESULTS))
        else $error("result count over cap");

    // a packet is only built around a real target
    a_emit_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_ready) |-> (r_target != NO_TRIGGER))
        else $error("packet built without target");

endmodule
`default_nettype wire

FILE: tb/tb_trigger_id_event_builder.sv
// self-checking testbench for the trigger id event builder
`timescale 1ns / 100ps
`default_nettype none
module tb_trigger_id_event_builder;
    import tieb_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int EXP_DEPTH    = 1024;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_req        i_req;
    logic        o_valid;
    logic        i_ready;
    t_res        o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    trigger_id_event_builder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow state of the builder
    logic [31:0] sh_trig  [NUM_PRODUCERS][QUEUE_DEPTH];
    logic [15:0] sh_pay   [NUM_PRODUCERS][QUEUE_DEPTH];
    logic        sh_fill  [NUM_PRODUCERS][QUEUE_DEPTH];
    logic [31:0] sh_arr   [NUM_PRODUCERS][QUEUE_DEPTH];
    int          sh_head  [NUM_PRODUCERS];
    int          sh_cnt   [NUM_PRODUCERS];
    logic [31:0] sh_time;
    logic [3:0]  sh_mask;
    logic [15:0] sh_timeout;

    // expected results in order, written by the sender and read by the checker
    t_res        exp_fifo [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    int          errors;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("trigger_id_event_builder regression: fail");
            $finish;
        end
    end

    // receiver: random stall, plus long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result %h", $time, o_res);
                errors++;
            end else begin
                exp_r = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_res !== exp_r) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, o_res);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] front_age(int p);
        return sh_time - sh_arr[p][sh_head[p]];
    endfunction

    // one build attempt; returns 1 and fills r when a packet goes out
    function automatic bit build_packet(output t_res r);
        logic [31:0] target;
        logic [31:0] max_age;
        bit          all_front;
        int          h;
        target = NO_TRIGGER;
        all_front = 1;
        r = '0;
        for (int p = 0; p < NUM_PRODUCERS; p++)
            if (sh_mask[p] && sh_cnt[p] > 0 && sh_trig[p][sh_head[p]] < target)
                target = sh_trig[p][sh_head[p]];
        if (target == NO_TRIGGER)
            return 0;
        for (int p = 0; p < NUM_PRODUCERS; p++) begin
            if (!sh_mask[p])
                continue;
            if (sh_cnt[p] == 0) begin
                max_age = 0;
                for (int q = 0; q < NUM_PRODUCERS; q++)
                    if (sh_cnt[q] > 0 && front_age(q) > max_age)
                        max_age = front_age(q);
                if (max_age >= sh_timeout) begin
                    h = (sh_head[p] + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    sh_head[p] = h;
                    sh_trig[p][h] = target;
                    sh_pay[p][h] = '0;
                    sh_fill[p][h] = 1;
                    sh_arr[p][h] = sh_time;
                    sh_cnt[p]++;
                end else begin
                    all_front = 0;
                end
            end else if (sh_trig[p][sh_head[p]] != target) begin
                if (front_age(p) >= sh_timeout && sh_cnt[p] < QUEUE_DEPTH) begin
                    h = (sh_head[p] + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    sh_head[p] = h;
                    sh_trig[p][h] = target;
                    sh_pay[p][h] = '0;
                    sh_fill[p][h] = 1;
                    sh_arr[p][h] = sh_time;
                    sh_cnt[p]++;
                end else begin
                    all_front = 0;
                end
            end
        end
        if (!all_front)
            return 0;
        r.kind = KIND_PACKET;
        r.packet_trigger = target;
        for (int p = 0; p < NUM_PRODUCERS; p++) begin
            if (!sh_mask[p] || sh_cnt[p] == 0)
                continue;
            h = sh_head[p];
            case (p)
                0: r.payload_p0 = sh_pay[p][h];
                1: r.payload_p1 = sh_pay[p][h];
                2: r.payload_p2 = sh_pay[p][h];
                default: r.payload_p3 = sh_pay[p][h];
            endcase
            r.present_mask[p] = 1'b1;
            r.filler_mask[p] = sh_fill[p][h];
            sh_head[p] = (h + 1) % QUEUE_DEPTH;
            sh_cnt[p]--;
        end
        r.any_fill = (r.filler_mask != 0);
        return 1;
    endfunction

    // predict all results caused by one request
    task automatic predict_request(input t_req rq);
        t_res pending [MAX_RESULTS];
        int   n_res;
        t_res r;
        int   p;
        int   s;
        n_res = 0;
        if (rq.req_type == REQ_TICK) begin
            sh_time = sh_time + 1;
        end else begin
            p = rq.producer;
            if (sh_cnt[p] >= QUEUE_DEPTH) begin
                r = '0;
                r.kind = KIND_DROP;
                r.packet_trigger = rq.trigger_id;
                case (p)
                    0: r.payload_p0 = rq.payload;
                    1: r.payload_p1 = rq.payload;
                    2: r.payload_p2 = rq.payload;
                    default: r.payload_p3 = rq.payload;
                endcase
                r.present_mask[p] = 1'b1;
                pending[n_res] = r;
                n_res++;
            end else begin
                s = (sh_head[p] + sh_cnt[p]) % QUEUE_DEPTH;
                sh_trig[p][s] = rq.trigger_id;
                sh_pay[p][s] = rq.payload;
                sh_fill[p][s] = 0;
                sh_arr[p][s] = sh_time;
                sh_cnt[p]++;
            end
        end
        while (n_res < MAX_RESULTS && build_packet(r)) begin
            pending[n_res] = r;
            n_res++;
        end
        if (n_res > 0)
            pending[n_res - 1].last = 1'b1;
        for (int k = 0; k < n_res; k++) begin
            exp_fifo[exp_wr % EXP_DEPTH] = pending[k];
            exp_wr++;
        end
    endtask

    // send one request, predicting on acceptance
    task automatic send_request(input t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req <= rq;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predict_request(rq);
    endtask

    task automatic send_arrival(input int p, input logic [31:0] trig, input logic [15:0] pay);
        t_req rq;
        rq.req_type = REQ_ARRIVAL;
        rq.producer = p[1:0];
        rq.trigger_id = trig;
        rq.payload = pay;
        send_request(rq);
    endtask

    task automatic send_tick();
        t_req rq;
        rq = '0;
        rq.req_type = REQ_TICK;
        rq.producer = 2'($urandom);
        rq.trigger_id = $urandom;
        rq.payload = 16'($urandom);
        send_request(rq);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // apb write while idle, then read back
    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [31:0] rb;
        i_valid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ENABLED) begin
            sh_mask = value[3:0];
            rb = {28'h0, value[3:0]};
        end else begin
            sh_timeout = value[15:0];
            rb = {16'h0, value[15:0]};
        end
        @(posedge i_clk);
        if (prdata !== rb) begin
            $display("%0t: register mismatch expected %h actual %h", $time, rb, prdata);
            errors++;
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // extremes of every field, drops, fillers, no-target
    task automatic test_directed();
        set_idling(0, 0);
        write_register(REG_TIMEOUT, 32'd0);
        send_arrival(0, 32'd5, 16'hFFFF);
        send_arrival(1, 32'd5, 16'h0000);
        send_arrival(2, 32'd5, 16'h1234);
        send_arrival(3, 32'd5, 16'hABCD);
        send_arrival(3, 32'd0, 16'h0001);
        send_arrival(2, NO_TRIGGER, 16'h8000);
        send_tick();
        wait_drained();
        // only all-ones fronts: no target
        write_register(REG_ENABLED, 32'h4);
        send_tick();
        wait_drained();
        // fill one queue and overflow it
        write_register(REG_TIMEOUT, 32'd65535);
        write_register(REG_ENABLED, 32'hF);
        for (int k = 0; k < QUEUE_DEPTH + 2; k++)
            send_arrival(1, 32'hFFFF_FFFE - k, 16'(k));
        wait_drained();
    endtask

    // random mostly well-formed trigger sequences
    task automatic test_random(input int n_items);
        logic [31:0] trig;
        trig = $urandom_range(1000);
        for (int k = 0; k < n_items; k++) begin
            case ($urandom_range(9))
                0, 1, 2: send_tick();
                3: send_arrival($urandom_range(3), $urandom, 16'($urandom));
                default: begin
                    send_arrival($urandom_range(3), trig + $urandom_range(2), 16'($urandom));
                    if ($urandom_range(3) == 0)
                        trig = trig + 1;
                end
            endcase
        end
        wait_drained();
    endtask

    task automatic test_config_sweep();
        write_register(REG_ENABLED, 32'h0);
        write_register(REG_TIMEOUT, 32'd2);
        test_random(20);
        write_register(REG_ENABLED, 32'h5);
        write_register(REG_TIMEOUT, 32'd1);
        test_random(40);
        write_register(REG_ENABLED, 32'hF);
        write_register(REG_TIMEOUT, 32'd3);
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_off_cycles = 600;
        test_random(40);
        set_idling(0, 0);
        test_random(10);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        exp_wr = 0;
        exp_rd = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sh_time = '0;
        sh_mask = MASK_RST;
        sh_timeout = TIMEOUT_RST;
        for (int p = 0; p < NUM_PRODUCERS; p++) begin
            sh_head[p] = 0;
            sh_cnt[p] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        set_idling(0, 0);
        test_random(90);
        set_idling(67, 0);
        test_random(70);
        set_idling(0, 67);
        test_random(70);
        set_idling(10, 10);
        write_register(REG_TIMEOUT, 32'd6);
        test_random(70);
        test_backpressure();

        if (errors == 0)
            $display("trigger_id_event_builder regression: pass");
        else
            $display("trigger_id_event_builder regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
